/* sv/generational_slot_event_table_unit_assert.svh */
// assertion macros used by the slot event table back end
// expects signals clk and rst_n in the including module
`ifndef GENERATIONAL_SLOT_EVENT_TABLE_UNIT_ASSERT_SVH
`define GENERATIONAL_SLOT_EVENT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define GSET_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("slot event table check failed");

// next-cycle implication, disabled while in reset
`define GSET_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("slot event table check failed");

`endif

/* sv/gset_pkg.sv */
// types, codes and sizes for the generational slot event table
// no dependencies
package gset_pkg;

  localparam int SLOT_COUNT     = 32;
  localparam int SLOT_BITS      = $clog2(SLOT_COUNT);
  localparam int KEY_BITS       = 16;
  localparam int ITEM_SLOT_BITS = 5;
  localparam int ITEM_KEY_BITS  = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  // command codes on the input channel
  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_POLL    = 3'd2;
  localparam logic [2:0] CMD_SIGNAL  = 3'd3;
  localparam logic [2:0] CMD_DISABLE = 3'd4;
  localparam logic [2:0] CMD_ARM     = 3'd5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FLAG_NONE    = 2'd0,
    FLAG_CHANGED = 2'd1,
    FLAG_STICKY  = 2'd2
  } flag_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_POLL    = 3'd2,
    OP_SIGNAL  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_ARM     = 3'd5,
    OP_BAD     = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]                cmd;
    logic [ITEM_SLOT_BITS-1:0] slot_in;
    logic [ITEM_KEY_BITS-1:0]  key_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [ITEM_SLOT_BITS-1:0] slot_out;
    logic [ITEM_KEY_BITS-1:0]  key_out;
    logic [1:0]                flag_out;
  } out_item_t;

  typedef struct packed {
    op_t                  op;
    logic [SLOT_BITS-1:0] slot;
    logic [KEY_BITS-1:0]  key;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/gset_front.sv */
// front end: accepts commands and classifies them for the back end
// depends on gset_pkg
module gset_front import gset_pkg::*; (
  input  logic      start,
  input  in_item_t  in_item,
  input  q_status_t q_status,
  output logic      busy,
  output logic      push,
  output q_item_t   push_item
);

  logic in_range;

  // a beat is taken whenever the queue has room
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  // slot index must lie inside the table
  assign in_range = (32'(in_item.slot_in) < SLOT_COUNT);

  // decode command, fold out-of-range handles and unused codes into bad
  always_comb begin
    push_item.slot = in_item.slot_in[SLOT_BITS-1:0];
    push_item.key  = in_item.key_in[KEY_BITS-1:0];
    unique case (in_item.cmd)
      CMD_CREATE:  push_item.op = OP_CREATE;
      CMD_DESTROY: push_item.op = in_range ? OP_DESTROY : OP_BAD;
      CMD_POLL:    push_item.op = in_range ? OP_POLL    : OP_BAD;
      CMD_SIGNAL:  push_item.op = in_range ? OP_SIGNAL  : OP_BAD;
      CMD_DISABLE: push_item.op = in_range ? OP_DISABLE : OP_BAD;
      CMD_ARM:     push_item.op = in_range ? OP_ARM     : OP_BAD;
      default:     push_item.op = OP_BAD;
    endcase
  end

endmodule

/* sv/gset_queue.sv */
// short fifo between front and back end
// depends on gset_pkg
module gset_queue import gset_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_item_t   head,
  output q_status_t q_status
);

  q_item_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign q_status.full  = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head           = entry_r[rd_ptr_r];

  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;

  // pointer and count update with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/gset_back.sv */
// back end: slot table state, handle check, command execution, result register
// depends on gset_pkg and the assertion macro header
`include "generational_slot_event_table_unit_assert.svh"

module gset_back import gset_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_item_t   head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [SLOT_COUNT-1:0] busy_r, busy_nxt;
  logic [KEY_BITS-1:0]   gen_r  [SLOT_COUNT];
  logic [KEY_BITS-1:0]   gen_nxt[SLOT_COUNT];
  flag_t                 flag_r  [SLOT_COUNT];
  flag_t                 flag_nxt[SLOT_COUNT];
  logic                  out_strobe_r;
  out_item_t             out_r, out_nxt;

  logic [SLOT_COUNT-1:0] free_vec, free_onehot;
  logic [SLOT_BITS-1:0]  free_idx;
  logic                  table_full;
  logic [SLOT_BITS-1:0]  sel;
  logic [KEY_BITS-1:0]   gen_cur, key_bump;
  flag_t                 flag_cur, flag_kept;
  logic                  handle_ok;

  // one item executes every cycle the queue holds one
  assign pop = !q_status.empty;

  // lowest free slot: isolate lowest set bit, then encode
  assign free_vec    = ~busy_r;
  assign free_onehot = free_vec & (~free_vec + 1'b1);
  assign table_full  = (free_vec == '0);

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      for (int b = 0; b < SLOT_BITS; b++) begin
        if (((i >> b) & 1) == 1) begin
          free_idx[b] = free_idx[b] | free_onehot[i];
        end
      end
    end
  end

  // read the addressed slot
  assign sel       = (head.op == OP_CREATE) ? free_idx : head.slot;
  assign gen_cur   = gen_r[sel];
  assign flag_cur  = flag_r[sel];
  assign handle_ok = busy_r[sel] && (gen_cur == head.key);
  assign flag_kept = (flag_cur == FLAG_STICKY) ? FLAG_STICKY : FLAG_NONE;

  // next key skips zero on wrap
  always_comb begin
    key_bump = gen_cur + 1'b1;
    if (key_bump == '0) begin
      key_bump = KEY_BITS'(1);
    end
  end

  // execute the command at the head of the queue
  always_comb begin
    busy_nxt = busy_r;
    gen_nxt  = gen_r;
    flag_nxt = flag_r;
    out_nxt  = '0;
    out_nxt.status = ST_OK;
    if (pop) begin
      if (head.op == OP_CREATE) begin
        if (table_full) begin
          out_nxt.status = ST_FULL;
        end else begin
          busy_nxt[sel]    = 1'b1;
          gen_nxt[sel]     = key_bump;
          flag_nxt[sel]    = FLAG_NONE;
          out_nxt.slot_out = ITEM_SLOT_BITS'(free_idx);
          out_nxt.key_out  = ITEM_KEY_BITS'(key_bump);
        end
      end else if (head.op == OP_BAD || !handle_ok) begin
        out_nxt.status = ST_BAD;
      end else begin
        unique case (head.op)
          OP_DESTROY: busy_nxt[sel] = 1'b0;
          OP_POLL: begin
            out_nxt.flag_out = flag_cur;
            flag_nxt[sel]    = flag_kept;
          end
          OP_SIGNAL: begin
            if (flag_cur != FLAG_STICKY) begin
              flag_nxt[sel] = FLAG_CHANGED;
            end
          end
          OP_DISABLE: flag_nxt[sel] = FLAG_STICKY;
          OP_ARM:     flag_nxt[sel] = flag_kept;
          default:    out_nxt.status = ST_BAD;
        endcase
      end
    end
  end

  // slot table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        gen_r[i]  <= '0;
        flag_r[i] <= FLAG_NONE;
      end
    end else begin
      busy_r <= busy_nxt;
      gen_r  <= gen_nxt;
      flag_r <= flag_nxt;
    end
  end

  // result register, one beat per executed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // checks
  `GSET_ASSERT_NXT(a_pop_gives_result, pop, out_strobe_r)
  `GSET_ASSERT_NXT(a_create_marks_busy, pop && head.op == OP_CREATE && !table_full, busy_r[$past(free_idx)])
  `GSET_ASSERT_NXT(a_create_key_nonzero, pop && head.op == OP_CREATE && !table_full, out_r.key_out != '0)
  `GSET_ASSERT_IMP(a_full_result_clean, out_strobe_r && out_r.status == ST_FULL, out_r.slot_out == '0 && out_r.key_out == '0 && out_r.flag_out == '0)
  `GSET_ASSERT_NXT(a_sticky_holds, pop && head.op != OP_CREATE && flag_cur == FLAG_STICKY, flag_r[$past(sel)] == FLAG_STICKY)

endmodule

/* sv/generational_slot_event_table_unit.sv */
// Generational slot event table: top level joining front end, queue and back end
// depends on gset_pkg, gset_front, gset_queue, gset_back
//
// Usage:
//   Commands enter on in_item (cmd, slot_in, key_in) and are taken at a clock
//   edge where start is high and busy is low. busy rises only when the
//   two-entry command queue is full.
//   Each command yields exactly one result beat on out_item (status, slot_out,
//   key_out, flag_out), shown for one cycle with out_strobe high. The receiver
//   cannot hold results off and none is needed: the back end executes one
//   command per cycle.
//   Path: a taken command is written into the queue, then executed from the
//   queue head, which updates the slot table and registers its result beat.
//   Throughput: one command per cycle; the back end's single read-modify-write
//   of the slot table (lowest-free-slot encoder plus handle compare) sets it.
//   Reset (rst_n low, synchronous) empties the queue and clears all busy bits,
//   keys and flags at once; commands may be issued as soon as rst_n is high again.
module generational_slot_event_table_unit import gset_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  q_status_t q_status;
  logic      push, pop;
  q_item_t   push_item, head;

  // classify incoming commands
  gset_front u_front (
    .start     (start),
    .in_item   (in_item),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  // decouple front and back
  gset_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // execute against the slot table
  gset_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
